@@ hdl/mau_pkg.sv @@
`default_nettype none
package mau_pkg;
  localparam int unsigned XLEN = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned RIDX_W = 5;
  localparam int unsigned CNT_W = 6;

  localparam logic [RIDX_W-1:0] LO_REG = 5'd30;
  localparam logic [RIDX_W-1:0] HI_REG = 5'd31;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  typedef struct packed {
    logic [5:0]       opcode;
    logic [RIDX_W-1:0] rs_index;
    logic [RIDX_W-1:0] rt_index;
    logic [RIDX_W-1:0] rd_index;
    logic [RIDX_W-1:0] shift_amount;
    logic [5:0]       func;
    logic [XLEN-1:0]  immediate;
  } req_t;

  typedef struct packed {
    logic              main_write;
    logic [RIDX_W-1:0] main_index;
    logic [XLEN-1:0]   main_value;
    logic              hilo_write;
    logic [XLEN-1:0]   lo_result;
    logic [XLEN-1:0]   hi_result;
    logic              unknown_op;
  } rsp_t;
endpackage
`default_nettype wire

@@ hdl/mau_if.sv @@
`default_nettype none
interface mau_req_if;
  import mau_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mau_rsp_if;
  import mau_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/mips_alu_with_register_file.sv @@
// MIPS integer ALU with a private 32 x 32 register file (r30 = LO, r31 = HI).
// Channels: req (sink) carries one decoded instruction; rsp (source) carries
// one result per request, reporting the register write, the LO/HI write, or
// an unknown-code flag. Both use valid/ready; a transfer happens when both
// are high at a rising clk_i.
// Sequence: a request is taken, then the register file is read for rs and
// then rt through one read port, then the operation runs. Shifts walk one
// bit position a cycle; MFHI and MFLO read LO or HI through that port; multiply
// and divide run a radix-2 iteration a cycle for 32 steps, then a step that
// closes the count and a sign fix-up step. Other operations, and a divide by
// zero, finish at once. One request is in flight at a time; the next is taken
// no earlier than the cycle the result is taken.
// Reset: rst_ni low clears all control; the register file then reads as zero
// through one valid bit per entry, no clearing pass needed.
// Stall: while rsp.ready is low the result stays in its register, and the
// block takes no new request until it is gone.
`default_nettype none
module mips_alu_with_register_file (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mau_req_if.sink   req,
  mau_rsp_if.source rsp
);
  import mau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_ITER = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_SHL  = 2'd1;
  localparam logic [1:0] K_SHR  = 2'd2;
  localparam logic [1:0] K_MOV  = 2'd3;

  logic [2:0]          state_q, state_d;
  req_t                ins_q;
  logic [XLEN-1:0]     mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [XLEN-1:0]     rdata_q;
  logic [RIDX_W-1:0]   raddr;
  logic [XLEN-1:0]     a_q, b_q;
  logic [XLEN-1:0]     acc_q, aux_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                neg_q, negr_q, fill_q;
  logic                is_mul_q, is_div_q;
  logic [1:0]          kind_q;
  logic                out_v_q;
  rsp_t                out_q;
  logic                wr_en;
  logic [RIDX_W-1:0]   wr_addr;
  logic [XLEN-1:0]     wr_data;
  logic                hl_en;
  logic                exec_busy;
  logic [1:0]          exec_kind;
  logic [CNT_W-1:0]    exec_cnt;

  assign req.ready   = (state_q == S_IDLE) && (!out_v_q || rsp.ready);
  assign rsp.valid   = out_v_q;
  assign rsp.payload = out_q;

  always_comb begin
    case (state_q)
      S_RDA:   raddr = ins_q.rs_index;
      S_RDB:   raddr = ins_q.rt_index;
      S_EXEC:  raddr = (ins_q.func == FN_MFHI) ? HI_REG : LO_REG;
      default: raddr = ins_q.rs_index;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (hl_en) begin
      mem[LO_REG] <= out_q.lo_result;
      mem[HI_REG] <= out_q.hi_result;
    end
  end

  logic rvld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr];
    end
  end

  logic [XLEN-1:0] rval;
  assign rval = rvld_q ? rdata_q : '0;

  logic [XLEN:0]   dif;
  logic [XLEN:0]   rem_sh;
  logic            div_ge;
  logic [XLEN:0]   msum;
  assign rem_sh = {aux_q, acc_q[XLEN-1]};
  assign div_ge = rem_sh >= {1'b0, b_q};
  assign dif    = rem_sh - {1'b0, b_q};
  assign msum   = {1'b0, aux_q} + {1'b0, (acc_q[0] ? b_q : '0)};

  logic [2*XLEN-1:0] prod_fix;
  assign prod_fix = neg_q ? -{aux_q, acc_q} : {aux_q, acc_q};

  logic [XLEN-1:0] sum_ab, sub_ab, sum_ai;
  assign sum_ab = a_q + rval;
  assign sub_ab = a_q - rval;
  assign sum_ai = a_q + ins_q.immediate;

  function automatic logic slt_s(input logic [XLEN-1:0] x, input logic [XLEN-1:0] y);
    slt_s = (x ^ {1'b1, {(XLEN-1){1'b0}}}) < (y ^ {1'b1, {(XLEN-1){1'b0}}});
  endfunction

  always_comb begin
    exec_busy = 1'b0;
    exec_kind = K_NONE;
    exec_cnt  = '0;
    if (ins_q.opcode == OP_RTYPE) begin
      case (ins_q.func)
        FN_SLL, FN_SRL, FN_SRA: begin
          exec_busy = 1'b1;
          exec_kind = (ins_q.func == FN_SLL) ? K_SHL : K_SHR;
          exec_cnt  = {1'b0, ins_q.shift_amount};
        end
        FN_SLLV, FN_SRLV: begin
          exec_busy = 1'b1;
          exec_kind = (ins_q.func == FN_SLLV) ? K_SHL : K_SHR;
          exec_cnt  = {1'b0, a_q[RIDX_W-1:0]};
        end
        FN_MFHI, FN_MFLO: begin
          exec_busy = 1'b1;
          exec_kind = K_MOV;
        end
        FN_MULT, FN_MULTU: begin
          exec_busy = 1'b1;
          exec_cnt  = CNT_W'(XLEN);
        end
        FN_DIV, FN_DIVU: begin
          if (rval != '0) begin
            exec_busy = 1'b1;
            exec_cnt  = CNT_W'(XLEN);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    hl_en   = 1'b0;
    case (state_q)
      S_IDLE:  if (req.valid && req.ready) state_d = S_RDA;
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_EXEC;
      S_EXEC:  state_d = exec_busy ? S_ITER : S_DONE;
      S_ITER:  if (cnt_q == '0) state_d = (is_mul_q || is_div_q) ? S_FIX : S_DONE;
      S_FIX:   state_d = S_DONE;
      S_DONE: begin
        state_d = S_IDLE;
        hl_en   = out_q.hilo_write;
        if (out_q.main_write) begin
          wr_en = 1'b1; wr_addr = out_q.main_index; wr_data = out_q.main_value;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      out_v_q  <= 1'b0;
      is_mul_q <= 1'b0;
      is_div_q <= 1'b0;
      kind_q   <= K_NONE;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE) out_v_q <= 1'b1;
      else if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (hl_en) begin
        vld_q[LO_REG] <= 1'b1;
        vld_q[HI_REG] <= 1'b1;
      end
      if (state_q == S_EXEC) begin
        is_mul_q <= (ins_q.opcode == OP_RTYPE)
                    && (ins_q.func == FN_MULT || ins_q.func == FN_MULTU);
        is_div_q <= (ins_q.opcode == OP_RTYPE)
                    && (ins_q.func == FN_DIV || ins_q.func == FN_DIVU) && (rval != '0);
        kind_q   <= exec_kind;
        cnt_q    <= exec_cnt;
      end else if (state_q == S_ITER && cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Datapath.
  rsp_t            out_d;
  logic [XLEN-1:0] a_d, b_d, acc_d, aux_d;
  logic            neg_d, negr_d, fill_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    aux_d  = aux_q;
    neg_d  = neg_q;
    negr_d = negr_q;
    fill_d = fill_q;
    out_d  = out_q;
    case (state_q)
      S_RDB: a_d = rval;
      S_EXEC: begin
        b_d    = rval;
        acc_d  = rval;
        aux_d  = '0;
        neg_d  = 1'b0;
        negr_d = 1'b0;
        fill_d = 1'b0;
        out_d  = '0;
        out_d.main_write = 1'b1;
        if (ins_q.opcode == OP_RTYPE) begin
          out_d.main_index = ins_q.rd_index;
          case (ins_q.func)
            FN_SLL, FN_SLLV, FN_SRL, FN_SRLV, FN_MFHI, FN_MFLO: ;
            FN_SRA: fill_d = rval[XLEN-1];
            FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
              out_d.main_write = 1'b0;
              out_d.main_index = '0;
              out_d.hilo_write = 1'b1;
              if (ins_q.func == FN_MULT || ins_q.func == FN_DIV) begin
                acc_d  = a_q[XLEN-1] ? -a_q : a_q;
                b_d    = rval[XLEN-1] ? -rval : rval;
                neg_d  = a_q[XLEN-1] ^ rval[XLEN-1];
                negr_d = a_q[XLEN-1];
              end else begin
                acc_d = a_q;
              end
              if ((ins_q.func == FN_DIV || ins_q.func == FN_DIVU) && rval == '0) begin
                out_d.lo_result = '1;
                out_d.hi_result = a_q;
              end
            end
            FN_ADD, FN_ADDU: out_d.main_value = sum_ab;
            FN_SUB, FN_SUBU: out_d.main_value = sub_ab;
            FN_AND: out_d.main_value = a_q & rval;
            FN_OR:  out_d.main_value = a_q | rval;
            FN_XOR: out_d.main_value = a_q ^ rval;
            FN_SLT: out_d.main_value = {{(XLEN-1){1'b0}}, slt_s(a_q, rval)};
            FN_SLTU: out_d.main_value = {{(XLEN-1){1'b0}}, (a_q < rval)};
            default: begin
              out_d.main_write = 1'b0;
              out_d.main_index = '0;
              out_d.unknown_op = 1'b1;
            end
          endcase
        end else begin
          out_d.main_index = ins_q.rt_index;
          case (ins_q.opcode)
            OP_ADDI, OP_ADDIU: out_d.main_value = sum_ai;
            OP_SLTI:  out_d.main_value = {{(XLEN-1){1'b0}}, slt_s(a_q, ins_q.immediate)};
            OP_SLTIU: out_d.main_value = {{(XLEN-1){1'b0}}, (a_q < ins_q.immediate)};
            default: begin
              out_d.main_write = 1'b0;
              out_d.main_index = '0;
              out_d.unknown_op = 1'b1;
            end
          endcase
        end
      end
      S_ITER: begin
        if (is_mul_q) begin
          if (cnt_q != '0) begin
            acc_d = {msum[0], acc_q[XLEN-1:1]};
            aux_d = msum[XLEN:1];
          end
        end else if (is_div_q) begin
          if (cnt_q != '0) begin
            if (div_ge) begin
              aux_d = dif[XLEN-1:0];
              acc_d = {acc_q[XLEN-2:0], 1'b1};
            end else begin
              aux_d = rem_sh[XLEN-1:0];
              acc_d = {acc_q[XLEN-2:0], 1'b0};
            end
          end
        end else if (kind_q == K_MOV) begin
          out_d.main_value = rval;
        end else if (cnt_q != '0) begin
          if (kind_q == K_SHL) acc_d = {acc_q[XLEN-2:0], 1'b0};
          else acc_d = {fill_q, acc_q[XLEN-1:1]};
        end else begin
          out_d.main_value = acc_q;
        end
      end
      S_FIX: begin
        if (is_mul_q) begin
          out_d.hi_result = prod_fix[2*XLEN-1:XLEN];
          out_d.lo_result = prod_fix[XLEN-1:0];
        end else begin
          out_d.lo_result = neg_q ? -acc_q : acc_q;
          out_d.hi_result = negr_q ? -aux_q : aux_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) ins_q <= req.payload;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    aux_q  <= aux_d;
    neg_q  <= neg_d;
    negr_q <= negr_d;
    fill_q <= fill_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> (state_q == S_RDA)) else $error("request not started");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !(rsp.payload.main_write && rsp.payload.hilo_write))
    else $error("both writes set");
  a_unk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.payload.unknown_op) |-> !rsp.payload.main_write)
    else $error("unknown op wrote");
`endif
endmodule
`default_nettype wire

@@ tb/mips_alu_with_register_file_tb.sv @@
`timescale 1ns / 1ps
module mips_alu_with_register_file_tb;
  import mau_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  mau_req_if req_ch ();
  mau_rsp_if rsp_ch ();

  mips_alu_with_register_file u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  logic [XLEN-1:0] shadow_regs [REG_COUNT];
  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int fail_count = 0;
  int req_gap = 0;
  int rsp_gap = 0;
  bit stim_done = 1'b0;
  bit hold_req = 1'b0;

  localparam logic [5:0] FN_LIST [20] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV,
    FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB,
    FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_SLT, FN_SLTU};
  localparam logic [5:0] OP_LIST [4] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU};

  function automatic rsp_t execute_instr(req_t r);
    rsp_t o;
    logic [XLEN-1:0] a, b, q, rm, ma, mb;
    logic [63:0] p;
    o = '0;
    a = shadow_regs[r.rs_index];
    b = shadow_regs[r.rt_index];
    if (r.opcode == OP_RTYPE) begin
      o.main_write = 1'b1;
      o.main_index = r.rd_index;
      case (r.func)
        FN_SLL: o.main_value = b << r.shift_amount;
        FN_SRL: o.main_value = b >> r.shift_amount;
        FN_SRA: o.main_value = $signed(b) >>> r.shift_amount;
        FN_SLLV: o.main_value = b << a[4:0];
        FN_SRLV: o.main_value = b >> a[4:0];
        FN_MFHI: o.main_value = shadow_regs[HI_REG];
        FN_MFLO: o.main_value = shadow_regs[LO_REG];
        FN_MULT, FN_MULTU: begin
          if (r.func == FN_MULT) p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          else p = {32'd0, a} * {32'd0, b};
          o.main_write = 1'b0;
          o.hilo_write = 1'b1;
          o.lo_result = p[31:0];
          o.hi_result = p[63:32];
        end
        FN_DIV, FN_DIVU: begin
          o.main_write = 1'b0;
          o.hilo_write = 1'b1;
          if (b == 0) begin
            o.lo_result = '1;
            o.hi_result = a;
          end else if (r.func == FN_DIVU) begin
            o.lo_result = a / b;
            o.hi_result = a % b;
          end else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            rm = ma % mb;
            o.lo_result = (a[31] != b[31]) ? -q : q;
            o.hi_result = a[31] ? -rm : rm;
          end
        end
        FN_ADD, FN_ADDU: o.main_value = a + b;
        FN_SUB, FN_SUBU: o.main_value = a - b;
        FN_AND: o.main_value = a & b;
        FN_OR: o.main_value = a | b;
        FN_XOR: o.main_value = a ^ b;
        FN_SLT: o.main_value = ($signed(a) < $signed(b)) ? 1 : 0;
        FN_SLTU: o.main_value = (a < b) ? 1 : 0;
        default: begin
          o.main_write = 1'b0;
          o.main_index = '0;
          o.unknown_op = 1'b1;
        end
      endcase
    end else begin
      o.main_write = 1'b1;
      o.main_index = r.rt_index;
      case (r.opcode)
        OP_ADDI, OP_ADDIU: o.main_value = a + r.immediate;
        OP_SLTI: o.main_value = ($signed(a) < $signed(r.immediate)) ? 1 : 0;
        OP_SLTIU: o.main_value = (a < r.immediate) ? 1 : 0;
        default: begin
          o.main_write = 1'b0;
          o.main_index = '0;
          o.unknown_op = 1'b1;
        end
      endcase
    end
    if (!o.main_write) o.main_index = '0;
    if (o.main_write) shadow_regs[o.main_index] = o.main_value;
    if (o.hilo_write) begin
      shadow_regs[LO_REG] = o.lo_result;
      shadow_regs[HI_REG] = o.hi_result;
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t mk_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                logic [4:0] rd, logic [4:0] sh);
    req_t r;
    r = '0;
    r.opcode = OP_RTYPE;
    r.func = fn;
    r.rs_index = rs;
    r.rt_index = rt;
    r.rd_index = rd;
    r.shift_amount = sh;
    r.immediate = $urandom();
    return r;
  endfunction

  function automatic req_t mk_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                logic [31:0] imm);
    req_t r;
    r = '0;
    r.opcode = op;
    r.rs_index = rs;
    r.rt_index = rt;
    r.immediate = imm;
    r.rd_index = 5'($urandom());
    r.shift_amount = 5'($urandom());
    r.func = 6'($urandom());
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) r = mk_i(OP_LIST[$urandom_range(0, 3)], 5'($urandom()), 5'($urandom()),
                         rand_word());
    else if (k < 92) r = mk_r(FN_LIST[$urandom_range(0, 19)], 5'($urandom()),
                              5'($urandom()), 5'($urandom()), 5'($urandom()));
    else begin
      r = ($urandom_range(0, 1) == 1)
          ? mk_r(6'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                 5'($urandom()))
          : mk_i(6'($urandom()), 5'($urandom()), 5'($urandom()), $urandom());
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_ch.ready) begin
    end else begin
      if (req_ch.valid) begin
        expected_rsps.push_back(execute_instr(req_ch.payload));
        req_gap = $urandom_range(0, 19);
      end
      if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_req) begin
        req_ch.payload <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t got, want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result %h", got);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.main_write !== want.main_write) begin
            $error("main_write exp %h got %h", want.main_write, got.main_write); fail_count++;
          end
          if (got.main_index !== want.main_index) begin
            $error("main_index exp %h got %h", want.main_index, got.main_index); fail_count++;
          end
          if (got.main_value !== want.main_value) begin
            $error("main_value exp %h got %h", want.main_value, got.main_value); fail_count++;
          end
          if (got.hilo_write !== want.hilo_write) begin
            $error("hilo_write exp %h got %h", want.hilo_write, got.hilo_write); fail_count++;
          end
          if (got.lo_result !== want.lo_result) begin
            $error("lo_result exp %h got %h", want.lo_result, got.lo_result); fail_count++;
          end
          if (got.hi_result !== want.hi_result) begin
            $error("hi_result exp %h got %h", want.hi_result, got.hi_result); fail_count++;
          end
          if (got.unknown_op !== want.unknown_op) begin
            $error("unknown_op exp %h got %h", want.unknown_op, got.unknown_op); fail_count++;
          end
        end
        rsp_gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) rsp_gap = 0;
      end
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
    pending_reqs.push_back(mk_i(OP_ADDIU, 5'd0, 5'd1, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_i(OP_ADDI, 5'd0, 5'd2, 32'h8000_0000));
    pending_reqs.push_back(mk_i(OP_ADDI, 5'd0, 5'd0, 32'h7FFF_FFFF));
    pending_reqs.push_back(mk_i(OP_SLTI, 5'd2, 5'd3, 32'h0000_0001));
    pending_reqs.push_back(mk_i(OP_SLTIU, 5'd2, 5'd4, 32'h0000_0001));
    pending_reqs.push_back(mk_r(FN_SRA, 5'd0, 5'd2, 5'd5, 5'd31));
    pending_reqs.push_back(mk_r(FN_SLL, 5'd0, 5'd1, 5'd6, 5'd31));
    pending_reqs.push_back(mk_r(FN_SRL, 5'd0, 5'd1, 5'd7, 5'd0));
    pending_reqs.push_back(mk_r(FN_SLLV, 5'd1, 5'd1, 5'd8, 5'd0));
    pending_reqs.push_back(mk_r(FN_SRLV, 5'd2, 5'd1, 5'd9, 5'd0));
    pending_reqs.push_back(mk_r(FN_DIV, 5'd2, 5'd1, 5'd10, 5'd0));
    pending_reqs.push_back(mk_r(FN_MFLO, 5'd0, 5'd0, 5'd11, 5'd0));
    pending_reqs.push_back(mk_r(FN_MFHI, 5'd0, 5'd0, 5'd12, 5'd0));
    pending_reqs.push_back(mk_r(FN_DIVU, 5'd1, 5'd13, 5'd13, 5'd0));
    pending_reqs.push_back(mk_r(FN_DIV, 5'd1, 5'd13, 5'd13, 5'd0));
    pending_reqs.push_back(mk_i(OP_ADDI, 5'd0, 5'd14, 32'hFFFF_FFF9));
    pending_reqs.push_back(mk_i(OP_ADDI, 5'd0, 5'd15, 32'd2));
    pending_reqs.push_back(mk_r(FN_DIV, 5'd14, 5'd15, 5'd0, 5'd0));
    pending_reqs.push_back(mk_r(FN_MULT, 5'd2, 5'd1, 5'd0, 5'd0));
    pending_reqs.push_back(mk_r(FN_MULTU, 5'd1, 5'd1, 5'd0, 5'd0));
    pending_reqs.push_back(mk_r(FN_SLT, 5'd2, 5'd0, 5'd16, 5'd0));
    pending_reqs.push_back(mk_r(FN_SLTU, 5'd2, 5'd0, 5'd17, 5'd0));
    pending_reqs.push_back(mk_r(FN_SUB, 5'd2, 5'd1, 5'd18, 5'd0));
    pending_reqs.push_back(mk_r(6'h3F, 5'd1, 5'd1, 5'd1, 5'd31));
    pending_reqs.push_back(mk_i(6'h3F, 5'd1, 5'd1, 32'h0));
    for (int i = 0; i < 400; i++) pending_reqs.push_back(rand_req());
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() < 200);
    @(posedge clk_i);
    hold_req <= 1'b1;
    wait (!req_ch.valid && expected_rsps.size() == 0);
    @(posedge clk_i);
    hold_req <= 1'b0;
    wait (pending_reqs.size() == 0 && !req_ch.valid);
    wait (expected_rsps.size() == 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
